[rtl/dll_pkg.sv]
package dll_pkg;

  localparam int unsigned OP_W = 4;

  // node table and list head sizes, fixed by the field widths
  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned LIST_COUNT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INIT          = 4'd0,
    OP_ADD_FIRST     = 4'd1,
    OP_ADD_LAST      = 4'd2,
    OP_INSERT_AFTER  = 4'd3,
    OP_INSERT_BEFORE = 4'd4,
    OP_REMOVE        = 4'd5,
    OP_CUT_END       = 4'd6,
    OP_TRUNCATE_END  = 4'd7,
    OP_READ          = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_COUNT  = 2'd1,
    ST_MALFORM = 2'd2
  } status_t;

  // link port selectors
  typedef enum logic [1:0] {
    LNK_NONE = 2'd0,
    LNK_PREV = 2'd1,
    LNK_NEXT = 2'd2,
    LNK_BOTH = 2'd3
  } lnk_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;      // capture input item and head
    logic     rd_a;      // read links of node
    logic     rd_b;      // read links of anchor / neighbor
    logic     decide;    // evaluate operation, issue writes
    logic     wr2;       // second round of link writes
    logic     out_load;  // latch result
  } dll_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_b;   // operation needs anchor links
    logic need_wr2; // a second write round is needed
  } dll_sts_t;

endpackage

[rtl/doubly_linked_list_engine.sv]
// one operation at a time: after the input transfer the node links are read, then
// the anchor or head end links when needed, then the decision and link writes, then a
// second write round for add and insert that relink (one write port per link memory),
// then the result is loaded; the next transfer is in the cycle after that load
// a result held by m_tready stalls the next item before its result is loaded
// rst (synchronous) sets all list heads empty; link memories are not cleared
module doubly_linked_list_engine
  import dll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[3:0], list_index[7:4], node_index[17:8], anchor_index[27:18],
  // remove_count[38:28], zero fill
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], list_length[12:2], front_node[23:13], back_node[34:24],
  // node_prev[45:35], node_next[56:46], zero fill
  output logic [63:0] m_tdata
);

  dll_cmd_t cmd;
  dll_sts_t sts;
  logic [1:0]  status;
  logic [10:0] list_length, front_node, back_node, node_prev, node_next;

  dll_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .sts(sts), .cmd(cmd)
  );

  dll_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_opcode(s_tdata[3:0]), .in_list(s_tdata[7:4]),
    .in_node(s_tdata[17:8]), .in_anchor(s_tdata[27:18]),
    .in_count(s_tdata[38:28]),
    .status(status), .list_length(list_length), .front_node(front_node),
    .back_node(back_node), .node_prev(node_prev), .node_next(node_next)
  );

  assign m_tdata = {7'd0, node_next, node_prev, back_node, front_node,
                    list_length, status};

endmodule

[rtl/dll_ram.sv]
module dll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dll_ctrl.sv]
module dll_ctrl
  import dll_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dll_sts_t sts,
  output dll_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_DEC,
    S_WR2,
    S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_IDLE: ;
      S_RDA:  cmd.rd_a = 1'b1;
      S_RDB:  cmd.rd_b = 1'b1;
      S_DEC:  cmd.decide = 1'b1;
      S_WR2:  cmd.wr2 = 1'b1;
      S_OUT:  cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // sequencer: load, read node, optional read anchor, decide/write, optional second write, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register: set when loaded, cleared on transfer out
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (cmd.load) state <= S_RDA;
        S_RDA:  state <= sts.need_b ? S_RDB : S_DEC;
        S_RDB:  state <= S_DEC;
        S_DEC:  state <= sts.need_wr2 ? S_WR2 : S_OUT;
        S_WR2:  state <= S_OUT;
        S_OUT:  if (cmd.out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/dll_dp.sv]
module dll_dp
  import dll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dll_cmd_t    cmd,
  output dll_sts_t    sts,
  input  logic [3:0]  in_opcode,
  input  logic [3:0]  in_list,
  input  logic [9:0]  in_node,
  input  logic [9:0]  in_anchor,
  input  logic [10:0] in_count,
  output logic [1:0]  status,
  output logic [10:0] list_length,
  output logic [10:0] front_node,
  output logic [10:0] back_node,
  output logic [10:0] node_prev,
  output logic [10:0] node_next
);

  localparam int unsigned AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned LW  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam logic [10:0] NIL = 11'(NODE_COUNT);

  // heads live in flip-flops, cleared at reset
  logic [10:0] hfirst [LIST_COUNT];
  logic [10:0] hlast  [LIST_COUNT];
  logic [10:0] hlen   [LIST_COUNT];

  // captured item
  op_t         op;
  logic [3:0]  lst;
  logic [9:0]  nd, an;
  logic [10:0] cnt;
  logic        l_ok;
  logic [10:0] len, hf, hl;
  logic        list_in_ok;

  // link reads
  logic [10:0] nd_p, nd_n, b_p, b_n;

  // result waiting for the output register
  logic [1:0]  res_status;
  logic [10:0] res_len, res_front, res_back, res_prev, res_next;

  // link memories, one write port each
  logic          pwe, nwe;
  logic [AW-1:0] pwa, nwa, pra, nra;
  logic [10:0]   pwd, nwd, prd, nrd;

  dll_ram #(.WIDTH(11), .DEPTH(NODE_COUNT)) u_prev (
    .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd)
  );
  dll_ram #(.WIDTH(11), .DEPTH(NODE_COUNT)) u_next (
    .clk(clk), .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(nra), .rdata(nrd)
  );

  function automatic logic is_node(input logic [10:0] v);
    return v < 11'(NODE_COUNT);
  endfunction

  logic        nd_ok, an_ok;
  logic [10:0] nd11, an11, anc;
  assign nd11  = {1'b0, nd};
  assign an11  = {1'b0, an};
  assign nd_ok = is_node(nd11);
  assign an_ok = is_node(an11);
  assign list_in_ok = {1'b0, in_list} < 5'(LIST_COUNT);

  // anchor for add ops is the head end, for insert ops the anchor input
  always_comb begin
    case (op)
      OP_ADD_FIRST: anc = hf;
      OP_ADD_LAST:  anc = hl;
      default:      anc = an11;
    endcase
  end

  assign sts.need_b = l_ok && (op == OP_ADD_FIRST || op == OP_ADD_LAST ||
                      op == OP_INSERT_AFTER || op == OP_INSERT_BEFORE) &&
                      is_node(anc);

  // decision
  logic [1:0]  st;
  logic        after_m;  // link n after anchor
  logic        befor_m;
  logic        show;
  always_comb begin
    st = ST_OK;
    after_m = 1'b0;
    befor_m = 1'b0;
    show = 1'b1;
    if (!l_ok) begin
      st = ST_MALFORM;
    end else begin
      case (op)
        OP_INIT: show = 1'b0;
        OP_ADD_FIRST, OP_ADD_LAST: begin
          if (!nd_ok || len >= 11'(NODE_COUNT)) st = ST_MALFORM;
          else if (len != 11'd0) begin
            if (!is_node(anc) || anc == nd11) st = ST_MALFORM;
            else if (op == OP_ADD_FIRST) befor_m = 1'b1;
            else after_m = 1'b1;
          end
        end
        OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
          if (!nd_ok || !an_ok || nd == an || len >= 11'(NODE_COUNT))
            st = ST_MALFORM;
          else if (op == OP_INSERT_AFTER) after_m = 1'b1;
          else befor_m = 1'b1;
        end
        OP_REMOVE: if (!nd_ok || len == 11'd0) st = ST_MALFORM;
        OP_CUT_END: begin
          if (!nd_ok || cnt == 11'd0) st = ST_MALFORM;
          else if (cnt > len) st = ST_COUNT;
        end
        OP_TRUNCATE_END: begin
          if (!nd_ok) st = ST_MALFORM;
          else if (cnt > len) st = ST_COUNT;
        end
        OP_READ: ;
        default: st = ST_MALFORM;
      endcase
    end
  end

  // removal touches prev link of successor and next link of predecessor: one round
  // add/insert writes n.prev, n.next, plus anchor link and neighbor link
  logic ok;
  assign ok = (st == ST_OK);
  assign sts.need_wr2 = ok && (after_m || befor_m);

  // head update and writes at decide, second link round at wr2
  logic [10:0] new_len, new_f, new_l, rp, rn;
  logic [10:0] ca, pb;  // after: anchor's successor; before: anchor's predecessor
  assign ca = b_n;
  assign pb = b_p;

  always_comb begin
    new_len = len; new_f = hf; new_l = hl;
    pwe = 1'b0; nwe = 1'b0;
    pwa = nd[AW-1:0]; nwa = nd[AW-1:0];
    pwd = NIL; nwd = NIL;
    // node links are read at the input transfer, anchor links right after
    pra = cmd.load ? in_node[AW-1:0] : anc[AW-1:0];
    nra = pra;
    rp = nd_p; rn = nd_n;
    if (cmd.decide && ok) begin
      case (op)
        OP_INIT: begin new_len = 11'd0; new_f = NIL; new_l = NIL; end
        OP_ADD_FIRST, OP_ADD_LAST, OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
          new_len = len + 11'd1;
          pwe = 1'b1; nwe = 1'b1;
          if (after_m) begin
            pwd = anc; nwd = ca;
            if (!is_node(ca)) new_l = nd11;
            // a successor equal to the node ends up pointing back at itself
            rp = (ca == nd11) ? nd11 : anc; rn = ca;
          end else if (befor_m) begin
            pwd = pb; nwd = anc;
            if (!is_node(pb)) new_f = nd11;
            rp = pb; rn = (pb == nd11) ? nd11 : anc;
          end else begin
            new_f = nd11; new_l = nd11; new_len = 11'd1;
            rp = NIL; rn = NIL;
          end
        end
        OP_REMOVE: begin
          new_len = len - 11'd1;
          if (is_node(nd_p)) begin nwe = 1'b1; nwa = nd_p[AW-1:0]; nwd = nd_n; end
          else new_f = nd_n;
          if (is_node(nd_n)) begin pwe = 1'b1; pwa = nd_n[AW-1:0]; pwd = nd_p; end
          else new_l = nd_p;
        end
        OP_CUT_END: begin
          new_len = len - cnt;
          if (is_node(nd_p)) begin nwe = 1'b1; nwa = nd_p[AW-1:0]; nwd = NIL; end
          else new_f = NIL;
          new_l = is_node(nd_p) ? nd_p : NIL;
          // a node that is its own predecessor loses its next link
          rn = (nd_p == nd11) ? NIL : nd_n;
        end
        OP_TRUNCATE_END: begin
          if (cnt != 11'd0) begin
            nwe = 1'b1; nwd = NIL; new_l = nd11; new_len = len - cnt;
            rn = NIL;
          end
        end
        default: ;
      endcase
    end
    if (cmd.wr2) begin
      // anchor link and neighbor link
      if (after_m) begin
        nwe = 1'b1; nwa = anc[AW-1:0]; nwd = nd11;
        if (is_node(ca)) begin pwe = 1'b1; pwa = ca[AW-1:0]; pwd = nd11; end
      end else begin
        pwe = 1'b1; pwa = anc[AW-1:0]; pwd = nd11;
        if (is_node(pb)) begin nwe = 1'b1; nwa = pb[AW-1:0]; nwd = nd11; end
      end
    end
  end

  // list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        hfirst[i] <= NIL;
        hlast[i]  <= NIL;
        hlen[i]   <= 11'd0;
      end
    end else begin
      if (cmd.decide && ok && l_ok) begin
        hfirst[lst[LW-1:0]] <= new_f;
        hlast[lst[LW-1:0]]  <= new_l;
        hlen[lst[LW-1:0]]   <= new_len;
      end
    end
  end

  // item capture, link read data and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= op_t'(in_opcode);
      lst  <= in_list;
      nd   <= in_node;
      an   <= in_anchor;
      cnt  <= in_count;
      l_ok <= list_in_ok;
      if (list_in_ok) begin
        len <= hlen[in_list[LW-1:0]];
        hf  <= hfirst[in_list[LW-1:0]];
        hl  <= hlast[in_list[LW-1:0]];
      end else begin
        len <= 11'd0; hf <= NIL; hl <= NIL;
      end
    end
    if (cmd.rd_a) begin
      nd_p <= prd; nd_n <= nrd;
    end
    if (cmd.rd_b) begin
      b_p <= prd; b_n <= nrd;
    end
    if (cmd.decide) begin
      res_status <= st;
      res_len    <= new_len;
      res_front  <= new_f;
      res_back   <= new_l;
      res_prev   <= (ok && show && nd_ok) ? rp : NIL;
      res_next   <= (ok && show && nd_ok) ? rn : NIL;
    end
    if (cmd.out_load) begin
      status      <= res_status;
      list_length <= res_len;
      front_node  <= res_front;
      back_node   <= res_back;
      node_prev   <= res_prev;
      node_next   <= res_next;
    end
  end

endmodule

[sim/doubly_linked_list_engine_test.sv]
module doubly_linked_list_engine_test
  import dll_pkg::*;
;

  localparam int NODES = 1024;
  localparam int LISTS = 16;
  localparam logic [10:0] NIL = 11'd1024;
  localparam int RANDOM_ITEMS = 1130;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  lst;
    logic [9:0]  node;
    logic [9:0]  anchor;
    logic [10:0] cnt;
  } op_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] len;
    logic [10:0] first;
    logic [10:0] last;
    logic [10:0] prev;
    logic [10:0] next;
  } op_result_t;

  typedef struct {
    op_item_t   item;
    bit         typed;
    op_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  // shadow copy of the node table and list heads
  logic [10:0] prev_tab [NODES];
  logic [10:0] next_tab [NODES];
  logic [10:0] head_first [LISTS];
  logic [10:0] head_last [LISTS];
  logic [10:0] head_len [LISTS];
  // which links have been written, so reads of unwritten nodes are never caused
  bit          prev_set [NODES];
  bit          next_set [NODES];
  bit          in_pool [NODES];
  int          linked_nodes [$];

  op_result_t  pending_results [$];
  stim_row_t   directed [$];
  int          errors = 0;
  int          accepted = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;

  doubly_linked_list_engine uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("doubly_linked_list_engine_test: FAIL");
    $finish;
  end

  // track link writes
  function automatic void put_prev(int n, logic [10:0] v);
    prev_tab[n] = v;
    prev_set[n] = 1'b1;
    if (next_set[n] && !in_pool[n]) begin
      in_pool[n] = 1'b1;
      linked_nodes.push_back(n);
    end
  endfunction

  function automatic void put_next(int n, logic [10:0] v);
    next_tab[n] = v;
    next_set[n] = 1'b1;
    if (prev_set[n] && !in_pool[n]) begin
      in_pool[n] = 1'b1;
      linked_nodes.push_back(n);
    end
  endfunction

  function automatic void splice_after(int l, logic [10:0] a, logic [10:0] n);
    logic [10:0] c;
    c = next_tab[a];
    put_prev(n, a);
    put_next(n, c);
    if (!c[10]) put_prev(c, n);
    else head_last[l] = n;
    put_next(a, n);
    head_len[l] = head_len[l] + 11'd1;
  endfunction

  function automatic void splice_before(int l, logic [10:0] n, logic [10:0] b);
    logic [10:0] p;
    p = prev_tab[b];
    put_prev(n, p);
    put_next(n, b);
    if (!p[10]) put_next(p, n);
    else head_first[l] = n;
    put_prev(b, n);
    head_len[l] = head_len[l] + 11'd1;
  endfunction

  // predict one operation and update the shadow lists
  function automatic op_result_t list_op(op_item_t it);
    op_result_t  r;
    logic [10:0] len, a, p, c, nd, an;
    bit          show;
    int          l;
    l = it.lst;
    nd = {1'b0, it.node};
    an = {1'b0, it.anchor};
    len = head_len[l];
    show = 1'b1;
    r.status = ST_OK;
    case (it.op)
      OP_INIT: begin
        head_len[l] = '0;
        head_first[l] = NIL;
        head_last[l] = NIL;
        show = 1'b0;
      end
      OP_ADD_FIRST, OP_ADD_LAST: begin
        if (len >= NODES) r.status = ST_MALFORM;
        else if (len == 0) begin
          head_first[l] = nd;
          head_last[l] = nd;
          put_prev(nd, NIL);
          put_next(nd, NIL);
          head_len[l] = 11'd1;
        end else begin
          a = (it.op == OP_ADD_FIRST) ? head_first[l] : head_last[l];
          if (a[10] || a == nd) r.status = ST_MALFORM;
          else if (it.op == OP_ADD_FIRST) splice_before(l, nd, a);
          else splice_after(l, a, nd);
        end
      end
      OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
        if (nd == an || len >= NODES) r.status = ST_MALFORM;
        else if (it.op == OP_INSERT_AFTER) splice_after(l, an, nd);
        else splice_before(l, nd, an);
      end
      OP_REMOVE: begin
        if (len == 0) r.status = ST_MALFORM;
        else begin
          c = next_tab[nd];
          p = prev_tab[nd];
          if (!p[10]) put_next(p, c);
          else head_first[l] = c;
          if (!c[10]) put_prev(c, p);
          else head_last[l] = p;
          head_len[l] = len - 11'd1;
        end
      end
      OP_CUT_END: begin
        if (it.cnt == 0) r.status = ST_MALFORM;
        else if (it.cnt > len) r.status = ST_COUNT;
        else begin
          p = prev_tab[nd];
          if (!p[10]) put_next(p, NIL);
          else head_first[l] = NIL;
          head_last[l] = p[10] ? NIL : p;
          head_len[l] = len - it.cnt;
        end
      end
      OP_TRUNCATE_END: begin
        if (it.cnt > len) r.status = ST_COUNT;
        else if (it.cnt != 0) begin
          put_next(nd, NIL);
          head_last[l] = nd;
          head_len[l] = len - it.cnt;
        end
      end
      OP_READ: ;
      default: r.status = ST_MALFORM;
    endcase
    r.len = head_len[l];
    r.first = head_first[l];
    r.last = head_last[l];
    r.prev = (r.status == ST_OK && show) ? prev_tab[nd] : NIL;
    r.next = (r.status == ST_OK && show) ? next_tab[nd] : NIL;
    return r;
  endfunction

  function automatic logic [9:0] any_linked();
    return 10'(linked_nodes[$urandom_range(0, linked_nodes.size() - 1)]);
  endfunction

  // node at position k of list l, or some linked node if the walk breaks
  function automatic logic [9:0] walk_to(int l, int k);
    logic [10:0] n;
    n = head_first[l];
    for (int i = 0; i < k; i++) begin
      if (n[10] || !in_pool[n]) break;
      n = next_tab[n];
    end
    if (n[10] || !in_pool[n]) return any_linked();
    return n[9:0];
  endfunction

  // mostly well-formed list traffic with random content, some noise
  function automatic op_item_t next_op();
    op_item_t it;
    int       l, len, pick, k;
    l = $urandom_range(0, LISTS - 1);
    len = head_len[l];
    k = (len > 0) ? $urandom_range(0, len - 1) : 0;
    pick = $urandom_range(0, 99);
    it.lst = 4'(l);
    it.node = 10'($urandom_range(0, NODES - 1));
    it.anchor = (linked_nodes.size() > 0) ? any_linked() : '0;
    it.cnt = 11'($urandom_range(0, 2047));
    if (linked_nodes.size() == 0) pick = 20;
    if (len > 30 && $urandom_range(0, 1) == 1) pick = 0;
    if (pick < 6) begin
      it.op = OP_INIT;
    end else if (pick < 30) begin
      it.op = $urandom_range(0, 1) ? OP_ADD_FIRST : OP_ADD_LAST;
      if (len > 0 && (head_first[l][10] || head_last[l][10] ||
          !in_pool[head_first[l]] || !in_pool[head_last[l]])) it.op = OP_INIT;
    end else if (pick < 50) begin
      it.op = $urandom_range(0, 1) ? OP_INSERT_AFTER : OP_INSERT_BEFORE;
      it.anchor = (len > 0) ? walk_to(l, k) : any_linked();
    end else if (pick < 62) begin
      it.op = OP_REMOVE;
      it.node = (len > 0) ? walk_to(l, k) : any_linked();
    end else if (pick < 72) begin
      it.op = OP_CUT_END;
      it.node = (len > 0) ? walk_to(l, k) : any_linked();
      if ($urandom_range(0, 4) != 0) it.cnt = 11'(len - k);
    end else if (pick < 82) begin
      it.op = OP_TRUNCATE_END;
      it.node = (len > 0) ? walk_to(l, k) : any_linked();
      if ($urandom_range(0, 4) != 0) it.cnt = (len > 0) ? 11'(len - 1 - k) : 11'd0;
    end else if (pick < 94) begin
      it.op = OP_READ;
      it.node = (len > 0) ? walk_to(l, k) : any_linked();
    end else begin
      it.op = 4'($urandom_range(9, 15));
      it.node = any_linked();
    end
    return it;
  endfunction

  task automatic add_row(op_t op, int l, int n, int a, int c, bit t = 1'b0,
                         status_t st = ST_OK, int len = 0, int f = 1024,
                         int la = 1024, int p = 1024, int nx = 1024);
    stim_row_t row;
    row.item = '{op: op, lst: 4'(l), node: 10'(n), anchor: 10'(a), cnt: 11'(c)};
    row.typed = t;
    row.res = '{status: st, len: 11'(len), first: 11'(f), last: 11'(la),
                prev: 11'(p), next: 11'(nx)};
    directed.push_back(row);
  endtask

  task automatic mismatch(string field, logic [10:0] got, logic [10:0] want);
    $display("%0t result mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    errors++;
  endtask

  // offer one item; the predictor runs at the transfer edge
  task automatic send_op(op_item_t it, bit typed, op_result_t want);
    op_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {1'b0, it.cnt, it.anchor, it.node, it.lst, it.op};
    do @(posedge clk); while (!s_tready);
    r = list_op(it);
    pending_results.push_back(typed ? want : r);
    accepted++;
    if (accepted == 400) long_hold = 1'b1;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // result side: bursts of stall and one long hold-off
  initial begin
    @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready = 1'b0;
        for (int i = 0; i < 300; i++) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      m_tready = 1'b1;
      @(negedge clk);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    op_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{status: m_tdata[1:0], len: m_tdata[12:2], first: m_tdata[23:13],
              last: m_tdata[34:24], prev: m_tdata[45:35], next: m_tdata[56:46]};
      if (pending_results.size() == 0) begin
        $display("%0t result with nothing pending", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          mismatch("status", 11'(got.status), 11'(want.status));
        if (got.len !== want.len) mismatch("list_length", got.len, want.len);
        if (got.first !== want.first) mismatch("front_node", got.first, want.first);
        if (got.last !== want.last) mismatch("back_node", got.last, want.last);
        if (got.prev !== want.prev) mismatch("node_prev", got.prev, want.prev);
        if (got.next !== want.next) mismatch("node_next", got.next, want.next);
      end
    end
  end

  initial begin
    int wait_cycles;
    for (int i = 0; i < LISTS; i++) begin
      head_first[i] = NIL;
      head_last[i] = NIL;
      head_len[i] = '0;
    end
    // after reset, extremes and refusals
    add_row(OP_INIT, 15, 0, 0, 0, 1, ST_OK, 0);
    add_row(OP_ADD_LAST, 0, 1023, 0, 0, 1, ST_OK, 1, 1023, 1023);
    add_row(OP_ADD_FIRST, 0, 0, 0, 0, 1, ST_OK, 2, 0, 1023, 1024, 1023);
    add_row(OP_ADD_LAST, 0, 1023, 0, 0, 1, ST_MALFORM, 2, 0, 1023);
    add_row(OP_INSERT_AFTER, 0, 5, 0, 0);
    add_row(OP_INSERT_BEFORE, 0, 6, 1023, 0);
    add_row(OP_INSERT_AFTER, 0, 7, 7, 0, 1, ST_MALFORM, 4, 0, 1023);
    add_row(OP_READ, 0, 5, 0, 0);
    add_row(OP_REMOVE, 3, 5, 0, 0, 1, ST_MALFORM, 0);
    add_row(OP_CUT_END, 0, 6, 0, 0, 1, ST_MALFORM, 4, 0, 1023);
    add_row(OP_CUT_END, 0, 6, 0, 2047, 1, ST_COUNT, 4, 0, 1023);
    add_row(OP_TRUNCATE_END, 0, 1023, 0, 1024, 1, ST_COUNT, 4, 0, 1023);
    add_row(OP_TRUNCATE_END, 0, 5, 0, 0);
    add_row(op_t'(4'd9), 0, 5, 0, 0, 1, ST_MALFORM, 4, 0, 1023);
    add_row(op_t'(4'd15), 15, 1023, 1023, 2047, 1, ST_MALFORM, 0);
    add_row(OP_ADD_FIRST, 15, 1023, 0, 0);
    add_row(OP_CUT_END, 0, 6, 0, 2);
    add_row(OP_TRUNCATE_END, 0, 0, 0, 1);
    add_row(OP_REMOVE, 0, 0, 0, 0);
    add_row(OP_INSERT_BEFORE, 1, 1000, 5, 0);
    add_row(OP_READ, 1, 1000, 0, 0);
    add_row(OP_INIT, 0, 0, 0, 0, 1, ST_OK, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) send_op(directed[i].item, directed[i].typed, directed[i].res);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 150) quiet = 1'b1;
      send_op(next_op(), 1'b0, '0);
    end

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("doubly_linked_list_engine_test: PASS");
    end else begin
      $display("doubly_linked_list_engine_test: FAIL");
    end
    $finish;
  end

endmodule
